// ===== rtl/peer_liveness_table_macros.svh =====
// assertion macros used by the peer liveness table checker
`ifndef PEER_LIVENESS_TABLE_MACROS_SVH
`define PEER_LIVENESS_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define PLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define PLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/plt_pkg.sv =====
// types and constants of the peer liveness table
`default_nettype none

package plt_pkg;

  localparam int IP_W       = 32;
  localparam int PORT_W     = 16;
  localparam int TIME_W     = 16;
  localparam int RND_W      = 8;
  localparam int MOD_STEP_W = $clog2(RND_W);
  localparam int MASK_W     = 10;
  localparam int IDX_OUT_W  = 4;
  localparam int CNT_OUT_W  = 4;

  typedef enum logic [1:0] {
    OP_HELLO = 2'd0,
    OP_PONG  = 2'd1,
    OP_TICK  = 2'd2,
    OP_PICK  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_ADDED     = 3'd0,
    STAT_REFRESHED = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_PICKED    = 3'd4,
    STAT_NONE      = 3'd5,
    STAT_TICK      = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_END,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic [IP_W-1:0]    peer_ip;
    logic [PORT_W-1:0]  peer_port;
    logic [RND_W-1:0]   random_value;
  } plt_req_t;

  typedef struct packed {
    status_t              status;
    logic [IDX_OUT_W-1:0] entry_index;
    logic [IP_W-1:0]      entry_ip;
    logic [PORT_W-1:0]    entry_port;
    logic [MASK_W-1:0]    expired_mask;
    logic [CNT_OUT_W-1:0] live_count;
  } plt_rsp_t;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] last_seen;
  } plt_entry_t;

  typedef struct packed {
    logic capture;
    logic mod_step;
    logic scan;
    logic finish;
    logic load;
  } plt_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_done;
    logic mod_last;
    logic none_active;
    logic out_busy;
  } plt_sts_t;

endpackage

`default_nettype wire

// ===== rtl/plt_ctrl.sv =====
// sequencer of the peer liveness table
`default_nettype none

module plt_ctrl
  import plt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  op_t      req_op,
  output logic     req_stall,
  output plt_cmd_t cmd,
  input  plt_sts_t sts
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req_op == OP_PICK) begin
            state_next = sts.none_active ? S_END : S_MOD;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_MOD: begin
        if (sts.mod_last) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.hit || sts.scan_done) state_next = S_END;
      end
      S_END: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall   = 1'b0;
        cmd.capture = req_valid;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_END: begin
        cmd.finish = 1'b1;
      end
      S_DONE: begin
        cmd.load = !sts.out_busy;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/plt_datapath.sv =====
// slot memory, scan pipeline, remainder unit and result register
`default_nettype none

module plt_datapath
  import plt_pkg::*;
#(
  parameter int TABLE_DEPTH = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  plt_req_t          req_item,
  input  logic              cfg_valid,
  input  logic [TIME_W-1:0] cfg_data,
  input  plt_cmd_t          cmd,
  output plt_sts_t          sts,
  input  logic              rsp_stall,
  output logic              rsp_valid,
  output plt_rsp_t          rsp_item
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // configuration and table state
  logic [TIME_W-1:0]      timeout;
  logic [TIME_W-1:0]      time_now;
  logic [CW-1:0]          used;
  logic [CW-1:0]          act_cnt;
  logic [TABLE_DEPTH-1:0] active;
  plt_entry_t             mem [TABLE_DEPTH];

  // captured item
  op_t               op_q;
  logic [IP_W-1:0]   ip_q;
  logic [PORT_W-1:0] port_q;

  // scan pipeline
  logic [CW-1:0] idx;
  logic [CW-1:0] chk_idx;
  logic          chk_vld;
  plt_entry_t    rd_data;

  // remainder unit, rem doubles as the pick countdown
  logic [CW-1:0]         rem;
  logic [RND_W-1:0]      sh;
  logic [MOD_STEP_W-1:0] mod_left;

  // result being built
  logic              found;
  status_t           res_status;
  logic [IW-1:0]     res_index;
  logic [IP_W-1:0]   res_ip;
  logic [PORT_W-1:0] res_port;
  logic [MASK_W-1:0] res_mask;

  logic              rd_en;
  logic              eval;
  logic              slot_act;
  logic              match;
  logic [TIME_W-1:0] elapsed;
  logic              expire;
  logic              hit_c;
  logic              append;
  logic [CW:0]       mod_t;
  logic              mod_ge;
  logic [CW-1:0]     rem_next;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  plt_entry_t        mem_wdata;

  assign rd_en    = cmd.scan && (idx < used);
  assign eval     = cmd.scan && chk_vld;
  assign slot_act = active[chk_idx[IW-1:0]];
  assign match    = (rd_data.ip == ip_q) && (rd_data.port == port_q);
  assign elapsed  = time_now - rd_data.last_seen;
  assign expire   = slot_act && (elapsed > timeout);

  always_comb begin
    hit_c = 1'b0;
    unique case (op_q)
      OP_HELLO: hit_c = match;
      OP_PONG:  hit_c = slot_act && match;
      OP_TICK:  hit_c = 1'b0;
      OP_PICK:  hit_c = slot_act && (rem == '0);
      default:  hit_c = 1'b0;
    endcase
  end

  assign append = cmd.finish && (op_q == OP_HELLO) && !found && (used != DEPTH_C);

  // one restoring step of random_value modulo active count
  assign mod_t    = {rem, sh[RND_W-1]};
  assign mod_ge   = mod_t >= {1'b0, act_cnt};
  assign rem_next = mod_ge ? CW'(mod_t - {1'b0, act_cnt}) : mod_t[CW-1:0];

  assign sts.hit         = eval && hit_c;
  assign sts.scan_done   = !chk_vld && (idx >= used);
  assign sts.mod_last    = (mod_left == '0);
  assign sts.none_active = (act_cnt == '0);
  assign sts.out_busy    = rsp_valid && rsp_stall;

  assign mem_we    = (eval && hit_c && (op_q == OP_HELLO || op_q == OP_PONG)) || append;
  assign mem_waddr = append ? used[IW-1:0] : chk_idx[IW-1:0];
  assign mem_wdata = append ? {ip_q, port_q, time_now}
                            : {rd_data.ip, rd_data.port, time_now};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en) rd_data <= mem[idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      chk_vld <= 1'b0;
    end else if (cmd.capture) begin
      idx     <= '0;
      chk_vld <= 1'b0;
    end else if (cmd.scan) begin
      chk_vld <= rd_en;
      if (rd_en) idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) chk_idx <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout   <= TIME_W'(1);
      time_now  <= '0;
      used      <= '0;
      act_cnt   <= '0;
      active    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid) timeout <= cfg_data;
      if (cmd.capture && req_item.operation == OP_TICK) time_now <= time_now + 1'b1;
      if (eval && op_q == OP_HELLO && hit_c) begin
        active[chk_idx[IW-1:0]] <= 1'b1;
        if (!slot_act) act_cnt <= act_cnt + 1'b1;
      end
      if (eval && op_q == OP_TICK && expire) begin
        active[chk_idx[IW-1:0]] <= 1'b0;
        act_cnt <= act_cnt - 1'b1;
      end
      if (append) begin
        active[used[IW-1:0]] <= 1'b1;
        act_cnt <= act_cnt + 1'b1;
        used    <= used + 1'b1;
      end
      if (cmd.load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q       <= req_item.operation;
      ip_q       <= req_item.peer_ip;
      port_q     <= req_item.peer_port;
      rem        <= '0;
      sh         <= req_item.random_value;
      mod_left   <= MOD_STEP_W'(RND_W - 1);
      found      <= 1'b0;
      res_status <= STAT_TICK;
      res_index  <= '0;
      res_ip     <= '0;
      res_port   <= '0;
      res_mask   <= '0;
    end
    if (cmd.mod_step) begin
      rem      <= rem_next;
      sh       <= sh << 1;
      mod_left <= mod_left - 1'b1;
    end
    if (eval) begin
      if (hit_c) begin
        found      <= 1'b1;
        res_index  <= chk_idx[IW-1:0];
        if (op_q == OP_PICK) begin
          res_status <= STAT_PICKED;
          res_ip     <= rd_data.ip;
          res_port   <= rd_data.port;
        end else begin
          res_status <= STAT_REFRESHED;
        end
      end else if (op_q == OP_PICK && slot_act) begin
        rem <= rem - 1'b1;
      end
      if (op_q == OP_TICK && expire) begin
        res_mask <= res_mask | (MASK_W'(1) << chk_idx);
      end
    end
    if (cmd.finish) begin
      case (op_q)
        OP_HELLO: begin
          if (!found) begin
            if (used == DEPTH_C) begin
              res_status <= STAT_FULL;
            end else begin
              res_status <= STAT_ADDED;
              res_index  <= used[IW-1:0];
            end
          end
        end
        OP_PONG: begin
          if (!found) res_status <= STAT_NOT_FOUND;
        end
        OP_TICK: begin
          res_status <= STAT_TICK;
        end
        OP_PICK: begin
          if (!found) res_status <= STAT_NONE;
        end
        default: begin
          res_status <= STAT_TICK;
        end
      endcase
    end
    if (cmd.load) begin
      rsp_item.status       <= res_status;
      rsp_item.entry_index  <= IDX_OUT_W'(res_index);
      rsp_item.entry_ip     <= res_ip;
      rsp_item.entry_port   <= res_port;
      rsp_item.expired_mask <= res_mask;
      rsp_item.live_count   <= CNT_OUT_W'(act_cnt);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/peer_liveness_table.sv =====
// top level of the peer liveness table
`default_nettype none

// peer liveness table: keeps up to TABLE_DEPTH peers, each an address, a
// port, an active flag and the tick of its last refresh. one item is taken
// at a time; req_stall is high from the cycle after an item is accepted until
// its result has been placed in the output register, and a finished result
// waits there under rsp_stall while the next item is already accepted.
// hello, pong and tick scan the used slots in order, and a hello or pong
// that hits ends the scan early; pick first runs the bit-serial remainder
// of random_value by the active count and then scans up to the chosen
// active slot, and a pick with no active peer skips both. the slot scan
// reads the slot memory one entry per cycle. active flags live in
// flip-flops cleared by reset, so no clearing pass is needed. the timeout
// register may be written at any time through cfg_valid (cfg_ready is
// always high) but is meant to change only while the table is idle.

module peer_liveness_table
  import plt_pkg::*;
#(
  parameter int TABLE_DEPTH = 10
) (
  input  logic              clk,
  input  logic              rst,
  // request items
  input  logic              req_valid,
  output logic              req_stall,
  input  plt_req_t          req_item,
  // result items
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output plt_rsp_t          rsp_item,
  // timeout register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TIME_W-1:0] cfg_data
);

  plt_cmd_t cmd;
  plt_sts_t sts;

  // the register write never waits
  assign cfg_ready = 1'b1;

  // sequencer: accept, remainder, scan, finish, hand off
  plt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (req_item.operation),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // slot memory, active flags, counters and output register
  plt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_item  (req_item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp_item  (rsp_item)
  );

endmodule

`default_nettype wire

// ===== rtl/plt_checker.sv =====
// port-level checks of the peer liveness table and their binding
`default_nettype none
`include "peer_liveness_table_macros.svh"

module plt_checker
  import plt_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_stall,
  input logic     rsp_valid,
  input logic     rsp_stall,
  input plt_rsp_t rsp_item
);

  `PLT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
                   rsp_valid && $stable(rsp_item), "stalled result changed")
  `PLT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
                   "second item taken while busy")
  `PLT_ASSERT_NOW(a_addr_only_pick, rsp_valid && rsp_item.status != STAT_PICKED,
                  rsp_item.entry_ip == '0 && rsp_item.entry_port == '0,
                  "address on non-pick result")
  `PLT_ASSERT_NOW(a_mask_only_tick, rsp_valid && rsp_item.status != STAT_TICK,
                  rsp_item.expired_mask == '0, "expired mask on non-tick result")
  `PLT_ASSERT_NOW(a_none_means_empty, rsp_valid && rsp_item.status == STAT_NONE,
                  rsp_item.live_count == '0, "none active with nonzero count")

endmodule

bind peer_liveness_table plt_checker u_checker (.*);

`default_nettype wire
